@@ rtl/invalid_page_reference_table_macros.svh @@
// Assertion macros for the invalid page reference table.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef INVALID_PAGE_REFERENCE_TABLE_MACROS_SVH
`define INVALID_PAGE_REFERENCE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPRT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("invalid page reference table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IPRT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("invalid page reference table: next-cycle check failed");

`endif

@@ rtl/iprt_pkg.sv @@
`timescale 1ns / 1ps
package iprt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REMOVED_W   = 7;

  // Item kinds
  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_RANGE = 2'd1;
  localparam logic [1:0] KIND_EXACT = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // One stored page reference
  typedef struct packed {
    logic [31:0] space;
    logic [31:0] database;
    logic [31:0] relation;
    logic [1:0]  fork_num;
    logic [31:0] block;
    logic        present;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item
  typedef struct packed {
    logic [1:0]           status;
    logic [REMOVED_W-1:0] removed_count;
    logic [31:0]          report_space;
    logic [31:0]          report_database;
    logic [31:0]          report_relation;
    logic [1:0]           report_fork;
    logic [31:0]          report_block;
    logic                 report_present;
    logic                 fault;
    logic                 last;
  } result_t;

endpackage

@@ rtl/iprt_in_if.sv @@
`timescale 1ns / 1ps
interface iprt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] space_number;
  logic [31:0] database_number;
  logic [31:0] relation_number;
  logic [1:0]  fork_req;
  logic [31:0] block;
  logic        page_present;

  modport source (
    output valid, kind, space_number, database_number, relation_number,
           fork_req, block, page_present,
    input  ready
  );

  modport sink (
    input  valid, kind, space_number, database_number, relation_number,
           fork_req, block, page_present,
    output ready
  );
endinterface

@@ rtl/iprt_out_if.sv @@
`timescale 1ns / 1ps
interface iprt_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [iprt_pkg::REMOVED_W-1:0] removed_count;
  logic [31:0]                    report_space;
  logic [31:0]                    report_database;
  logic [31:0]                    report_relation;
  logic [1:0]                     report_fork;
  logic [31:0]                    report_block;
  logic                           report_present;
  logic                           fault;
  logic                           last;

  modport source (
    output valid, status, removed_count, report_space, report_database,
           report_relation, report_fork, report_block, report_present,
           fault, last,
    input  ready
  );

  modport sink (
    input  valid, status, removed_count, report_space, report_database,
           report_relation, report_fork, report_block, report_present,
           fault, last,
    output ready
  );
endinterface

@@ rtl/iprt_ram.sv @@
`timescale 1ns / 1ps
module iprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/iprt_out_stage.sv @@
`timescale 1ns / 1ps
module iprt_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  iprt_pkg::result_t data,
  output logic              free,
  iprt_out_if.source        rsp
);
  import iprt_pkg::*;

  logic    valid;
  result_t hold;

  // Slot can take a new item when empty or when the held one leaves now
  assign free = !valid || rsp.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign rsp.valid           = valid;
  assign rsp.status          = hold.status;
  assign rsp.removed_count   = hold.removed_count;
  assign rsp.report_space    = hold.report_space;
  assign rsp.report_database = hold.report_database;
  assign rsp.report_relation = hold.report_relation;
  assign rsp.report_fork     = hold.report_fork;
  assign rsp.report_block    = hold.report_block;
  assign rsp.report_present  = hold.report_present;
  assign rsp.fault           = hold.fault;
  assign rsp.last            = hold.last;

endmodule

@@ rtl/invalid_page_reference_table.sv @@
`timescale 1ns / 1ps
// Every item but a check on an empty table sweeps the whole table once: one entry per
// cycle through the RAM read port, unless a check report cannot leave. A note or forget
// gives its result after the sweep. One item is handled at a time: the next is taken only
// once the table is idle again. A check streams one report per cycle during the sweep,
// slowed only by output stalls; on an empty table a check skips it and returns ST_NONE.
// Reset clears the valid bits and the fill count; the RAM contents are not cleared.
module invalid_page_reference_table (
  input  logic       clk,
  input  logic       rst,
  iprt_in_if.sink    cmd,
  iprt_out_if.source rsp
);
  import iprt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t                 state;
  logic [TABLE_DEPTH-1:0] valid_bits;
  logic [CNT_W-1:0]       fill;
  logic                   issue_on;
  logic                   eval_vld;

  logic [1:0]       kind;
  entry_t           key;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] eval_idx;
  logic             found;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] removed;

  entry_t  rd_entry;
  logic    accept;
  logic    slot_valid;
  logic    rel_hit;
  logic    blk_eq;
  logic    blk_ge;
  logic    forget_hit;
  logic    want_emit;
  logic    stall;
  logic    advance;
  logic    eval_last;
  logic    ram_re;
  logic    ram_we;
  logic    out_free;
  logic    out_load;
  result_t out_data;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // Compare the entry under evaluation with the item key
  assign slot_valid = valid_bits[eval_idx];
  assign rel_hit    = slot_valid && (rd_entry.space == key.space) &&
                      (rd_entry.database == key.database) &&
                      (rd_entry.relation == key.relation) &&
                      (rd_entry.fork_num == key.fork_num);
  assign blk_eq     = (rd_entry.block == key.block);
  assign blk_ge     = (rd_entry.block >= key.block);
  assign forget_hit = eval_vld && rel_hit && ((kind == KIND_RANGE) ? blk_ge : blk_eq) &&
                      ((kind == KIND_RANGE) || (kind == KIND_EXACT));

  // Sweep control: a report that cannot leave holds the whole sweep
  assign want_emit = (state == S_SCAN) && eval_vld && (kind == KIND_CHECK) && slot_valid;
  assign stall     = want_emit && !out_free;
  assign advance   = (state == S_SCAN) && !stall;
  assign eval_last = eval_vld && (eval_idx == LAST_IDX);
  assign ram_re    = advance && issue_on;

  // Insert the new key into the first free slot at the end of a note sweep
  assign ram_we = (state == S_FINISH) && out_free && (kind == KIND_NOTE) &&
                  !found && free_found;
  assign out_load = (want_emit && out_free) || ((state == S_FINISH) && out_free);

  // Build the result item
  always_comb begin
    out_data = '0;
    if (state == S_SCAN) begin
      out_data.status          = ST_REPORT;
      out_data.report_space    = rd_entry.space;
      out_data.report_database = rd_entry.database;
      out_data.report_relation = rd_entry.relation;
      out_data.report_fork     = rd_entry.fork_num;
      out_data.report_block    = rd_entry.block;
      out_data.report_present  = rd_entry.present;
      out_data.fault           = 1'b1;
      out_data.last            = (fill == CNT_W'(1));
    end else begin
      out_data.last = 1'b1;
      case (kind)
        KIND_NOTE: begin
          out_data.status = (found || free_found) ? ST_DONE : ST_FULL;
        end
        KIND_RANGE, KIND_EXACT: begin
          out_data.status        = ST_DONE;
          out_data.removed_count = REMOVED_W'(removed);
        end
        KIND_CHECK: begin
          out_data.status = ST_NONE;
        end
        default: begin
          out_data.status = ST_DONE;
        end
      endcase
    end
  end

  // Control state: sequencer, valid bits, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      fill       <= '0;
      issue_on   <= 1'b0;
      eval_vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            issue_on <= 1'b1;
            eval_vld <= 1'b0;
            if ((cmd.kind == KIND_CHECK) && (fill == '0)) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (advance) begin
            eval_vld <= issue_on;
            if (issue_on && (rd_idx == LAST_IDX)) begin
              issue_on <= 1'b0;
            end
            // Drop forgotten or reported entries
            if (forget_hit || want_emit) begin
              valid_bits[eval_idx] <= 1'b0;
              fill                 <= fill - CNT_W'(1);
            end
            if (eval_last) begin
              state <= (kind == KIND_CHECK) ? S_IDLE : S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (ram_we) begin
              valid_bits[free_idx] <= 1'b1;
              fill                 <= fill + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: key, sweep indexes, note and forget bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      kind           <= cmd.kind;
      key.space      <= cmd.space_number;
      key.database   <= cmd.database_number;
      key.relation   <= cmd.relation_number;
      key.fork_num   <= cmd.fork_req;
      key.block      <= cmd.block;
      key.present    <= cmd.page_present;
      rd_idx         <= '0;
      found          <= 1'b0;
      free_found     <= 1'b0;
      removed        <= '0;
    end else if (advance) begin
      eval_idx <= rd_idx;
      if (issue_on && (rd_idx != LAST_IDX)) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (eval_vld && (kind == KIND_NOTE)) begin
        if (rel_hit && blk_eq) begin
          found <= 1'b1;
        end
        if (!slot_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= eval_idx;
        end
      end
      if (eval_vld && forget_hit) begin
        removed <= removed + CNT_W'(1);
      end
    end
  end

  iprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (key),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  iprt_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .free (out_free),
    .rsp  (rsp)
  );

endmodule

@@ rtl/iprt_checker.sv @@
`timescale 1ns / 1ps
`include "invalid_page_reference_table_macros.svh"
module iprt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [1:0]                     rsp_status,
  input logic [iprt_pkg::REMOVED_W-1:0] rsp_removed_count,
  input logic                           rsp_fault,
  input logic                           rsp_last
);
  import iprt_pkg::*;

  // Only entry reports can be followed by more results of the same item
  `IPRT_ASSERT_NOW(a_nonlast_is_report, rsp_valid && !rsp_last, rsp_status == ST_REPORT)

  // Fault rides on entry reports and nothing else
  `IPRT_ASSERT_NOW(a_fault_on_report, rsp_valid, rsp_fault == (rsp_status == ST_REPORT))

  // One item at a time: after an accept the input side closes
  `IPRT_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready)

  // A result item not yet taken stays offered
  `IPRT_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)

  // Removed count is reported only with a done status
  `IPRT_ASSERT_NOW(a_removed_done, rsp_valid && (rsp_status != ST_DONE),
                   rsp_removed_count == '0)

endmodule

bind invalid_page_reference_table iprt_checker u_iprt_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_removed_count (rsp.removed_count),
  .rsp_fault         (rsp.fault),
  .rsp_last          (rsp.last)
);
